// ===== src/amf_pkg.sv =====
// Package for the above-mean filter with sorted merge.
// Holds opcodes, state encoding and the controller/datapath command and status structs.
// No dependencies.
package amf_pkg;

  localparam int VECTOR_DEPTH_DEF = 64;
  localparam int STORE_DEPTH_DEF  = 64;
  localparam int VALUE_W          = 32;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLOSE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CL_RD,
    ST_CL_TEST,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_SHIFT,
    ST_INS_WR,
    ST_CL_NEXT,
    ST_FL_RD,
    ST_FL_OUT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic add;         // Append in_value to the vector buffer.
    logic cl_start;    // Reset the close walk index.
    logic cl_rd;       // Read vector buffer at the walk index.
    logic cl_mul;      // Register value times count.
    logic cl_next;     // Advance walk index.
    logic cl_done;     // Clear vector count and sum.
    logic ins_start;   // Start an insertion scan at the top of the store.
    logic ins_rd;      // Read store at scan index minus one.
    logic ins_shift;   // Move the read entry up one place, scan down.
    logic ins_wr;      // Write the candidate at the scan index.
    logic ins_drop;    // Store full: set overflow.
    logic fl_start;    // Reset flush index.
    logic fl_rd;       // Read store at flush index.
    logic fl_load;     // Load output register.
    logic fl_done;     // Empty store, clear overflow.
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic vec_empty;
    logic cl_last;     // Walk index is the last element.
    logic keep;        // Element is at least the mean.
    logic store_full;
    logic scan_zero;   // Scan index reached the bottom.
    logic scan_gt;     // Read entry is greater or equal to the candidate.
    logic fl_last;     // Flush index is the last entry or store is empty.
  } stat_t;

endpackage

// ===== src/above_mean_filter_sorted_merge_top.sv =====
// Above-mean filter with sorted merge: add elements to a vector, close it to keep elements
// at or above the mean in a sorted store, flush to stream the store in ascending order.
// A close walks the vector after its accept cycle, testing each element against the mean
// and, for a kept element, scanning the store down from the top and moving greater or
// equal entries up one place before writing it, all over one single-port store. A flush
// gives beats while out_stall is low. The input stalls until each item is finished.
// Depends on amf_pkg, amf_ctrl and amf_datapath.
module above_mean_filter_sorted_merge_top #(
  parameter int VECTOR_DEPTH = amf_pkg::VECTOR_DEPTH_DEF,
  parameter int STORE_DEPTH  = amf_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sorted_value,
  output logic               out_is_last,
  output logic               out_is_empty,
  output logic               out_overflowed
);

  amf_pkg::cmd_t  cmd;
  amf_pkg::stat_t stat;

  amf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  amf_datapath #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .STORE_DEPTH  (STORE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_value         (in_value),
    .out_sorted_value (out_sorted_value),
    .out_is_last      (out_is_last),
    .out_is_empty     (out_is_empty),
    .out_overflowed   (out_overflowed)
  );

endmodule

// ===== src/amf_datapath.sv =====
// Datapath of the above-mean filter: vector buffer, sorted store, sum and output register.
// Depends on amf_pkg; driven by amf_ctrl through cmd_t and reports through stat_t.
module amf_datapath #(
  parameter int VECTOR_DEPTH = amf_pkg::VECTOR_DEPTH_DEF,
  parameter int STORE_DEPTH  = amf_pkg::STORE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  amf_pkg::cmd_t       cmd,
  output amf_pkg::stat_t      stat,
  input  logic signed [31:0]  in_value,
  output logic signed [31:0]  out_sorted_value,
  output logic                out_is_last,
  output logic                out_is_empty,
  output logic                out_overflowed
);

  localparam int VA_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam int VC_W = $clog2(VECTOR_DEPTH + 1);
  localparam int SA_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SC_W = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W = 32 + VC_W;
  localparam int PROD_W = 33 + VC_W;

  logic signed [31:0] vbuf [VECTOR_DEPTH];
  logic signed [31:0] sbuf [STORE_DEPTH];

  logic [VC_W-1:0]         vcount_r;
  logic signed [SUM_W-1:0] vsum_r;
  logic [VC_W-1:0]         walk_r;
  logic signed [31:0]      vrd_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [SC_W-1:0]         scount_r;
  logic [SC_W-1:0]         scan_r;
  logic signed [31:0]      srd_r;
  logic                    ovf_r;

  // Vector buffer port.
  always_ff @(posedge clk) begin
    if (cmd.add && (vcount_r < VC_W'(VECTOR_DEPTH))) begin
      vbuf[vcount_r[VA_W-1:0]] <= in_value;
    end
    if (cmd.cl_rd) begin
      vrd_r <= vbuf[walk_r[VA_W-1:0]];
    end
  end

  // Store port: one read or one write each cycle.
  logic [SC_W-1:0] srd_addr;
  always_comb begin
    srd_addr = cmd.fl_rd ? scan_r : (scan_r - SC_W'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_shift) begin
      sbuf[scan_r[SA_W-1:0]] <= srd_r;
    end else if (cmd.ins_wr) begin
      sbuf[scan_r[SA_W-1:0]] <= vrd_r;
    end
    if (cmd.ins_rd || cmd.fl_rd) begin
      srd_r <= sbuf[srd_addr[SA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cl_mul) begin
      prod_r <= PROD_W'(vrd_r) * $signed({1'b0, vcount_r});
    end
    if (cmd.fl_load) begin
      out_sorted_value <= (scount_r == '0) ? 32'sd0 : srd_r;
      out_is_last      <= stat.fl_last;
      out_is_empty     <= (scount_r == '0);
      out_overflowed   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      vsum_r   <= '0;
      walk_r   <= '0;
      scount_r <= '0;
      scan_r   <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (cmd.add) begin
        if (vcount_r < VC_W'(VECTOR_DEPTH)) begin
          vcount_r <= vcount_r + VC_W'(1);
          vsum_r   <= vsum_r + SUM_W'(in_value);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.cl_start) walk_r <= '0;
      if (cmd.cl_next)  walk_r <= walk_r + VC_W'(1);
      if (cmd.cl_done) begin
        vcount_r <= '0;
        vsum_r   <= '0;
      end
      if (cmd.ins_drop) ovf_r <= 1'b1;
      if (cmd.ins_start) scan_r <= scount_r;
      if (cmd.ins_shift) scan_r <= scan_r - SC_W'(1);
      if (cmd.ins_wr) scount_r <= scount_r + SC_W'(1);
      if (cmd.fl_start) scan_r <= '0;
      if (cmd.fl_load) scan_r <= scan_r + SC_W'(1);
      if (cmd.fl_done) begin
        scount_r <= '0;
        ovf_r    <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.vec_empty  = (vcount_r == '0);
    stat.cl_last    = (walk_r == vcount_r - VC_W'(1));
    stat.keep       = (prod_r >= PROD_W'(vsum_r));
    stat.store_full = (scount_r == SC_W'(STORE_DEPTH));
    stat.scan_zero  = (scan_r == '0);
    stat.scan_gt    = (srd_r >= vrd_r);
    stat.fl_last    = (scount_r == '0) || (scan_r == scount_r - SC_W'(1));
  end

endmodule

// ===== src/amf_ctrl.sv =====
// Controller state machine of the above-mean filter.
// Depends on amf_pkg; sequences amf_datapath through cmd_t.
module amf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_operation,
  output logic           out_valid,
  input  logic           out_stall,
  output amf_pkg::cmd_t  cmd,
  input  amf_pkg::stat_t stat
);

  amf_pkg::state_t state_r, state_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic            acc;

  assign in_stall  = (state_r != amf_pkg::ST_IDLE);
  assign out_valid = ovalid_r;
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= amf_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    ovalid_nxt = ovalid_r && out_stall;
    case (state_r)
      amf_pkg::ST_IDLE: begin
        if (acc) begin
          case (amf_pkg::op_t'(in_operation))
            amf_pkg::OP_ADD: cmd.add = 1'b1;
            amf_pkg::OP_CLOSE: begin
              if (!stat.vec_empty) begin
                cmd.cl_start = 1'b1;
                state_nxt    = amf_pkg::ST_CL_RD;
              end
            end
            amf_pkg::OP_FLUSH: begin
              cmd.fl_start = 1'b1;
              state_nxt    = amf_pkg::ST_FL_RD;
            end
            default: ;
          endcase
        end
      end
      amf_pkg::ST_CL_RD: begin
        cmd.cl_rd = 1'b1;
        state_nxt = amf_pkg::ST_CL_TEST;
      end
      amf_pkg::ST_CL_TEST: begin
        // The product registers here; the compare is taken next cycle.
        cmd.cl_mul = 1'b1;
        state_nxt  = amf_pkg::ST_INS_RD;
      end
      amf_pkg::ST_INS_RD: begin
        if (!stat.keep) begin
          state_nxt = amf_pkg::ST_CL_NEXT;
        end else if (stat.store_full) begin
          cmd.ins_drop = 1'b1;
          state_nxt    = amf_pkg::ST_CL_NEXT;
        end else begin
          cmd.ins_start = 1'b1;
          state_nxt     = amf_pkg::ST_INS_CMP;
        end
      end
      amf_pkg::ST_INS_CMP: begin
        // Scan down from the top, moving greater-or-equal entries up.
        if (stat.scan_zero) begin
          state_nxt = amf_pkg::ST_INS_WR;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = amf_pkg::ST_INS_SHIFT;
        end
      end
      amf_pkg::ST_INS_SHIFT: begin
        if (stat.scan_gt) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = amf_pkg::ST_INS_CMP;
        end else begin
          state_nxt = amf_pkg::ST_INS_WR;
        end
      end
      amf_pkg::ST_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = amf_pkg::ST_CL_NEXT;
      end
      amf_pkg::ST_CL_NEXT: begin
        if (stat.cl_last) begin
          cmd.cl_done = 1'b1;
          state_nxt   = amf_pkg::ST_IDLE;
        end else begin
          cmd.cl_next = 1'b1;
          state_nxt   = amf_pkg::ST_CL_RD;
        end
      end
      amf_pkg::ST_FL_RD: begin
        if (!ovalid_r || !out_stall) begin
          cmd.fl_rd = 1'b1;
          state_nxt = amf_pkg::ST_FL_OUT;
        end
      end
      amf_pkg::ST_FL_OUT: begin
        cmd.fl_load = 1'b1;
        ovalid_nxt  = 1'b1;
        if (stat.fl_last) begin
          cmd.fl_done = 1'b1;
          state_nxt   = amf_pkg::ST_IDLE;
        end else begin
          state_nxt = amf_pkg::ST_FL_RD;
        end
      end
      default: state_nxt = amf_pkg::ST_IDLE;
    endcase
  end

  // A new beat is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fl_load |-> !ovalid_r || !out_stall)
    else $error("output overwritten");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != amf_pkg::ST_IDLE) |-> in_stall)
    else $error("accept while busy");
  a_wr_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins_wr && cmd.ins_shift))
    else $error("store write conflict");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fl_done || cmd.cl_done) |=> state_r == amf_pkg::ST_IDLE)
    else $error("done without idle");

endmodule
